// ----- design/fdpp_pkg.sv -----
// Package: types, codes and constants shared by the framed decimal pair parser.
package fdpp_pkg;

  localparam logic [7:0] BYTE_START = 8'h9A;
  localparam logic [7:0] BYTE_END = 8'hA9;
  localparam logic [7:0] BYTE_COMMA = 8'h2C;
  localparam logic [7:0] BYTE_PLUS = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DIGIT0 = 8'd48;
  localparam logic [7:0] BYTE_DIGIT9 = 8'd57;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  localparam logic [2:0] TOKENS_USED = 3'd4;
  localparam int WINDOW_READS_DEFAULT = 47;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
  } fdpp_in_t;

  typedef struct packed {
    logic [7:0]  motor_id;
    logic [15:0] motor_command;
    logic        pair_valid;
    logic        frame_end;
    logic        frame_error;
  } fdpp_out_t;

  typedef enum logic [3:0] {
    KIND_TIMEOUT,
    KIND_START,
    KIND_END,
    KIND_NUL,
    KIND_COMMA,
    KIND_SPACE,
    KIND_PLUS,
    KIND_MINUS,
    KIND_DIGIT,
    KIND_OTHER
  } fdpp_kind_t;

  typedef struct packed {
    fdpp_kind_t kind;
    logic [3:0] digit;
  } fdpp_item_t;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } fdpp_phase_t;

endpackage

// ----- design/fdpp_front.sv -----
// Front end: accepts UART read beats and classifies each byte.
module fdpp_front (
  input  logic              item_valid,
  output logic              item_stall,
  input  fdpp_pkg::fdpp_in_t item,
  output logic              push,
  output fdpp_pkg::fdpp_item_t push_item,
  input  logic              queue_full
);
  import fdpp_pkg::*;

  logic [7:0] b;

  assign b = item.rx_byte;
  assign item_stall = queue_full;
  assign push = item_valid && !queue_full;

  always_comb begin
    push_item.digit = 4'(b - BYTE_DIGIT0);
    if (item.timed_out) begin
      push_item.kind = KIND_TIMEOUT;
    end else if (b == BYTE_START) begin
      push_item.kind = KIND_START;
    end else if (b == BYTE_END) begin
      push_item.kind = KIND_END;
    end else if (b == BYTE_NUL) begin
      push_item.kind = KIND_NUL;
    end else if (b == BYTE_COMMA) begin
      push_item.kind = KIND_COMMA;
    end else if (b == BYTE_SPACE || b inside {[BYTE_TAB:BYTE_CR]}) begin
      push_item.kind = KIND_SPACE;
    end else if (b == BYTE_PLUS) begin
      push_item.kind = KIND_PLUS;
    end else if (b == BYTE_MINUS) begin
      push_item.kind = KIND_MINUS;
    end else if (b inside {[BYTE_DIGIT0:BYTE_DIGIT9]}) begin
      push_item.kind = KIND_DIGIT;
    end else begin
      push_item.kind = KIND_OTHER;
    end
  end

endmodule

// ----- design/fdpp_queue.sv -----
// Short queue of classified bytes between the front and back ends.
module fdpp_queue #(
  parameter int DEPTH = fdpp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fdpp_pkg::fdpp_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output fdpp_pkg::fdpp_item_t head
);
  import fdpp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fdpp_item_t     slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/fdpp_back.sv -----
// Back end: token and frame state, result assembly and the output register.
module fdpp_back #(
  parameter int WINDOW_READS = fdpp_pkg::WINDOW_READS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 not_empty,
  input  fdpp_pkg::fdpp_item_t head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output fdpp_pkg::fdpp_out_t  result
);
  import fdpp_pkg::*;

  localparam int WW = $clog2(WINDOW_READS);
  localparam logic [WW:0] WIN_LIMIT = (WW + 1)'(WINDOW_READS);

  logic          in_frame, in_frame_next;
  logic [WW-1:0] window_reads, window_reads_next;
  logic [2:0]    tokens_seen, tokens_seen_next;
  logic          token_open, token_open_next;
  fdpp_phase_t   digit_phase, digit_phase_next;
  logic          value_negative, value_negative_next;
  logic [15:0]   value_accum, value_accum_next;
  logic [7:0]    held_id, held_id_next;
  logic          text_ended, text_ended_next;

  logic          do_close;
  logic          close_used;
  logic          pair;
  logic          fend;
  logic [15:0]   signed_value;
  logic [15:0]   accum_x10;
  logic [WW:0]   window_inc;
  logic          has_result;
  fdpp_out_t     result_next;

  assign pop = not_empty && (!result_valid || !result_stall);

  assign signed_value = value_negative ? 16'(~value_accum + 16'd1) : value_accum;
  assign accum_x10 = 16'({value_accum, 3'b000} + {value_accum, 1'b0});
  assign close_used = token_open && (tokens_seen < TOKENS_USED);
  assign window_inc = {1'b0, window_reads} + 1'b1;

  always_comb begin
    do_close = 1'b0;
    fend = 1'b0;
    in_frame_next = in_frame;
    tokens_seen_next = tokens_seen;
    token_open_next = token_open;
    digit_phase_next = digit_phase;
    value_negative_next = value_negative;
    value_accum_next = value_accum;
    held_id_next = held_id;
    text_ended_next = text_ended;
    window_reads_next = window_reads;

    if (head.kind == KIND_START) begin
      in_frame_next = 1'b1;
      tokens_seen_next = '0;
      text_ended_next = 1'b0;
      held_id_next = '0;
      token_open_next = 1'b0;
      digit_phase_next = PH_SPACE;
      value_negative_next = 1'b0;
      value_accum_next = '0;
    end else if (in_frame && head.kind != KIND_TIMEOUT) begin
      if (head.kind == KIND_END) begin
        fend = 1'b1;
        do_close = !text_ended;
      end else if (!text_ended) begin
        case (head.kind)
          KIND_NUL: begin
            do_close = 1'b1;
            text_ended_next = 1'b1;
          end
          KIND_COMMA: begin
            do_close = 1'b1;
          end
          default: begin
            token_open_next = 1'b1;
            case (digit_phase)
              PH_SPACE: begin
                if (head.kind == KIND_PLUS || head.kind == KIND_MINUS) begin
                  value_negative_next = (head.kind == KIND_MINUS);
                  digit_phase_next = PH_SIGN;
                end else if (head.kind == KIND_DIGIT) begin
                  value_accum_next = {12'd0, head.digit};
                  digit_phase_next = PH_DIGITS;
                end else if (head.kind != KIND_SPACE) begin
                  digit_phase_next = PH_DONE;
                end
              end
              PH_SIGN, PH_DIGITS: begin
                if (head.kind == KIND_DIGIT) begin
                  value_accum_next = 16'(accum_x10 + {12'd0, head.digit});
                  digit_phase_next = PH_DIGITS;
                end else begin
                  digit_phase_next = PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        endcase
      end
    end

    if (do_close) begin
      if (close_used) begin
        if (!tokens_seen[0]) begin
          held_id_next = signed_value[7:0];
        end
        tokens_seen_next = tokens_seen + 1'b1;
      end
      token_open_next = 1'b0;
      digit_phase_next = PH_SPACE;
      value_negative_next = 1'b0;
      value_accum_next = '0;
    end

    if (head.kind == KIND_TIMEOUT || fend || window_inc >= WIN_LIMIT) begin
      in_frame_next = 1'b0;
      tokens_seen_next = '0;
      text_ended_next = 1'b0;
      held_id_next = '0;
      token_open_next = 1'b0;
      digit_phase_next = PH_SPACE;
      value_negative_next = 1'b0;
      value_accum_next = '0;
      window_reads_next = '0;
    end else begin
      window_reads_next = window_inc[WW-1:0];
    end
  end

  always_comb begin
    pair = do_close && close_used && tokens_seen[0];
    has_result = pair || fend;
    result_next.motor_id = pair ? held_id : 8'd0;
    result_next.motor_command = pair ? signed_value : 16'd0;
    result_next.pair_valid = pair;
    result_next.frame_end = fend;
    result_next.frame_error = fend &&
        ((tokens_seen + 3'(pair || (do_close && close_used))) < TOKENS_USED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      window_reads <= '0;
      tokens_seen <= '0;
      token_open <= 1'b0;
      digit_phase <= PH_SPACE;
      value_negative <= 1'b0;
      value_accum <= '0;
      held_id <= '0;
      text_ended <= 1'b0;
      result_valid <= 1'b0;
    end else if (pop) begin
      in_frame <= in_frame_next;
      window_reads <= window_reads_next;
      tokens_seen <= tokens_seen_next;
      token_open <= token_open_next;
      digit_phase <= digit_phase_next;
      value_negative <= value_negative_next;
      value_accum <= value_accum_next;
      held_id <= held_id_next;
      text_ended <= text_ended_next;
      result_valid <= has_result;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

// ----- design/framed_decimal_pair_parser_unit.sv -----
// Top level of the framed decimal pair parser.
//
//   channel | signals                            | beat
//   --------+------------------------------------+-----------------------------------
//   item    | item_valid, item_stall, item       | one UART read: byte or timeout
//   result  | result_valid, result_stall, result | id/command pair, frame end, error
//
// One read is taken per cycle while the classifier queue has room.
// A read is written into the queue when it is taken, and loads the output
// register as it leaves the queue; reads that produce nothing give no beat.
// The back end takes one entry per cycle while the output register is free.
// A stalled result holds the output register; the four-entry queue then
// fills and item_stall rises. Reset is synchronous, with no clearing pass.
module framed_decimal_pair_parser_unit #(
  parameter int WINDOW_READS = fdpp_pkg::WINDOW_READS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  fdpp_pkg::fdpp_in_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output fdpp_pkg::fdpp_out_t result
);
  import fdpp_pkg::*;

  logic       push;
  fdpp_item_t push_item;
  logic       queue_full;
  logic       pop;
  logic       not_empty;
  fdpp_item_t head;

  fdpp_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  fdpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  fdpp_back #(
    .WINDOW_READS (WINDOW_READS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- design/fdpp_checker.sv -----
// Port-level checks for the framed decimal pair parser, bound to the top level.
module fdpp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_stall,
  input fdpp_pkg::fdpp_out_t result
);
  import fdpp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat right after reset");

  a_no_empty_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pair_valid || result.frame_end))
    else $error("result beat carries neither a pair nor a frame end");

  a_error_needs_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_error |-> result.frame_end)
    else $error("frame error without frame end");

  a_pair_zeroed: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.pair_valid |->
      (result.motor_id == 8'd0 && result.motor_command == 16'd0))
    else $error("id or command set without a pair");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

endmodule

bind framed_decimal_pair_parser_unit fdpp_checker u_fdpp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- bench/testbench.sv -----
// Self-checking bench for the framed decimal pair parser: directed and random reads.
`timescale 1ns / 1ps

module testbench;
  import fdpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  fdpp_in_t  item;
  logic      result_valid;
  logic      result_stall;
  fdpp_out_t result;

  logic        idle_on;
  logic        hold_req;
  int unsigned reads_sent;
  int unsigned errors;
  int unsigned cycle_count;

  logic        frame_open;
  int unsigned window_count;
  logic [2:0]  token_count;
  logic        token_live;
  fdpp_phase_t phase;
  logic        negate;
  logic [15:0] accum;
  logic [7:0]  id_held;
  logic        text_done;
  fdpp_out_t   outputs_due[$];

  framed_decimal_pair_parser_unit DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void drop_token();
    token_live = 1'b0;
    phase = PH_SPACE;
    negate = 1'b0;
    accum = '0;
  endfunction

  function automatic void drop_frame();
    frame_open = 1'b0;
    token_count = '0;
    text_done = 1'b0;
    id_held = '0;
    drop_token();
  endfunction

  function automatic logic close_token(output logic [7:0] id, output logic [15:0] cmd);
    logic [15:0] v;
    logic pair;
    id = '0;
    cmd = '0;
    pair = 1'b0;
    if (token_live && token_count < TOKENS_USED) begin
      v = negate ? 16'd0 - accum : accum;
      if (!token_count[0]) begin
        id_held = v[7:0];
      end else begin
        id = id_held;
        cmd = v;
        pair = 1'b1;
      end
      token_count++;
    end
    drop_token();
    return pair;
  endfunction

  function automatic void feed_char(logic [7:0] c);
    logic is_digit;
    logic is_space;
    is_digit = c >= BYTE_DIGIT0 && c <= BYTE_DIGIT9;
    is_space = c == BYTE_SPACE || (c >= BYTE_TAB && c <= BYTE_CR);
    token_live = 1'b1;
    case (phase)
      PH_SPACE: begin
        if (!is_space) begin
          if (c == BYTE_MINUS || c == BYTE_PLUS) begin
            negate = c == BYTE_MINUS;
            phase = PH_SIGN;
          end else if (is_digit) begin
            accum = 16'(c - BYTE_DIGIT0);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (is_digit) begin
          accum = accum * 16'd10 + 16'(c - BYTE_DIGIT0);
          phase = PH_DIGITS;
        end else begin
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_read(fdpp_in_t r);
    fdpp_out_t o;
    logic pair;
    logic closed;
    logic [7:0] id;
    logic [15:0] cmd;
    o = '0;
    pair = 1'b0;
    closed = 1'b0;
    id = '0;
    cmd = '0;
    if (r.timed_out) begin
      drop_frame();
      window_count = 0;
      return;
    end
    if (r.rx_byte == BYTE_START) begin
      drop_frame();
      frame_open = 1'b1;
    end else if (frame_open) begin
      if (r.rx_byte == BYTE_END) begin
        if (!text_done) pair = close_token(id, cmd);
        closed = 1'b1;
        o.frame_error = token_count < TOKENS_USED;
      end else if (!text_done) begin
        if (r.rx_byte == BYTE_NUL) begin
          pair = close_token(id, cmd);
          text_done = 1'b1;
        end else if (r.rx_byte == BYTE_COMMA) begin
          pair = close_token(id, cmd);
        end else begin
          feed_char(r.rx_byte);
        end
      end
    end
    if (closed) begin
      drop_frame();
      window_count = 0;
    end else begin
      window_count++;
      if (window_count >= WINDOW_READS_DEFAULT) begin
        drop_frame();
        window_count = 0;
      end
    end
    if (pair || closed) begin
      o.motor_id = id;
      o.motor_command = cmd;
      o.pair_valid = pair;
      o.frame_end = closed;
      outputs_due.push_back(o);
    end
  endfunction

  always @(posedge clk) begin
    fdpp_out_t want;
    if (!rst) begin
      if (item_valid && !item_stall) parse_read(item);
      if (result_valid && !result_stall) begin
        if (outputs_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %p", $time, result);
          errors++;
        end else begin
          want = outputs_due.pop_front();
          if (result.motor_id !== want.motor_id) begin
            $display("%0t: motor_id expected %0d got %0d", $time, want.motor_id,
                     result.motor_id);
            errors++;
          end
          if (result.motor_command !== want.motor_command) begin
            $display("%0t: motor_command expected %0d got %0d", $time,
                     want.motor_command, result.motor_command);
            errors++;
          end
          if (result.pair_valid !== want.pair_valid) begin
            $display("%0t: pair_valid expected %0b got %0b", $time, want.pair_valid,
                     result.pair_valid);
            errors++;
          end
          if (result.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
                     result.frame_end);
            errors++;
          end
          if (result.frame_error !== want.frame_error) begin
            $display("%0t: frame_error expected %0b got %0b", $time, want.frame_error,
                     result.frame_error);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // hold off the output for a long stretch on request, else short stalls if idle_on
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_read(input logic [7:0] b, input logic to);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{rx_byte: b, timed_out: to};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    reads_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_read(s[i], 1'b0);
  endtask

  task automatic send_random_token();
    int unsigned mag;
    case ($urandom_range(0, 3))
      0: mag = $urandom_range(0, 255);
      1: mag = $urandom_range(0, 65535);
      2: mag = $urandom_range(0, 999999);
      default: mag = $urandom_range(0, 9);
    endcase
    if ($urandom_range(0, 4) == 0)
      send_read($urandom_range(0, 1) ? BYTE_SPACE : 8'($urandom_range(BYTE_CR, BYTE_TAB)),
                1'b0);
    case ($urandom_range(0, 3))
      0: send_read(BYTE_MINUS, 1'b0);
      1: send_read(BYTE_PLUS, 1'b0);
      default: ;
    endcase
    if ($urandom_range(0, 15) != 0) send_text($sformatf("%0d", mag));
    if ($urandom_range(0, 7) == 0) send_read(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_random_frame();
    int unsigned n_tokens;
    n_tokens = $urandom_range(0, 9) < 7 ? 4 : $urandom_range(0, 6);
    send_read(BYTE_START, 1'b0);
    for (int t = 0; t < n_tokens; t++) begin
      if (t != 0) send_read(BYTE_COMMA, 1'b0);
      if ($urandom_range(0, 9) == 0) send_read(BYTE_COMMA, 1'b0);
      send_random_token();
    end
    case ($urandom_range(0, 19))
      0: begin
        send_read(BYTE_NUL, 1'b0);
        repeat ($urandom_range(0, 3)) send_read(8'($urandom_range(0, 255)), 1'b0);
        send_read(BYTE_END, 1'b0);
      end
      1: send_read(8'($urandom_range(0, 255)), 1'b1);
      2: ;
      default: send_read(BYTE_END, 1'b0);
    endcase
  endtask

  task automatic test_field_extremes();
    send_read(8'hFF, 1'b0);
    send_read(BYTE_START, 1'b0);
    send_text(" -1,,65539");
    send_read(BYTE_END, 1'b0);
    send_read(8'hFF, 1'b1);
  endtask

  task automatic test_restart_and_text_end();
    send_read(BYTE_START, 1'b0);
    send_text("7");
    send_read(BYTE_START, 1'b0);
    send_text("\t2,+9x5,30,4,9");
    send_read(BYTE_NUL, 1'b0);
    send_text("1,");
    send_read(BYTE_END, 1'b0);
  endtask

  task automatic test_timeout_abandon();
    send_read(BYTE_NUL, 1'b0);
    send_read(BYTE_START, 1'b0);
    send_text("5,6");
    send_read(8'h00, 1'b1);
    send_read(BYTE_END, 1'b0);
    send_read(BYTE_START, 1'b0);
    send_text("\r+0,-0");
    send_read(BYTE_END, 1'b0);
  endtask

  // emit a pair on the last read before the window runs out, then let it expire
  task automatic test_window_expiry();
    send_read(8'h55, 1'b1);
    send_read(BYTE_START, 1'b0);
    send_text("1,2");
    repeat (WINDOW_READS_DEFAULT - 6) send_read(BYTE_SPACE, 1'b0);
    send_read(BYTE_COMMA, 1'b0);
    send_read(BYTE_SPACE, 1'b0);
    send_read(BYTE_END, 1'b0);
    send_read(BYTE_START, 1'b0);
    send_text("3,4");
    send_read(BYTE_END, 1'b0);
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (4) begin
      send_read(BYTE_START, 1'b0);
      send_text("11,22,33,44");
      send_read(BYTE_END, 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int unsigned reads);
    int unsigned stop_at;
    stop_at = reads_sent + reads;
    while (reads_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0)
        send_random_frame();
      else
        repeat ($urandom_range(1, 6))
          send_read(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_traffic(150);
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    reads_sent = 0;
    errors = 0;
    cycle_count = 0;
    drop_frame();
    window_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_field_extremes();
    test_restart_and_text_end();
    test_timeout_abandon();
    test_window_expiry();
    test_output_hold();
    test_random_traffic(730);
    test_steady_stream();
    item_valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- framed_decimal_pair_parser_unit.f -----
design/fdpp_pkg.sv
design/fdpp_front.sv
design/fdpp_queue.sv
design/fdpp_back.sv
design/framed_decimal_pair_parser_unit.sv
design/fdpp_checker.sv
bench/testbench.sv
